FILE: hdl/rebl_pkg.sv
// Shared types and constants for the raster elevation bilinear lookup.
package rebl_pkg;

    // Operation codes carried in the input item's user field.
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_CELL_WIDTH  = 3'd2;
    localparam logic [2:0] REG_CELL_HEIGHT = 3'd3;
    localparam logic [2:0] REG_COLUMNS     = 3'd4;
    localparam logic [2:0] REG_ROWS        = 3'd5;
    localparam logic [2:0] REG_MISSING     = 3'd6;

    // Map values are Q31.16; positions keep 16 fraction bits.
    localparam int FRAC_BITS = 16;
    localparam int MAP_BITS  = 48;
    localparam int DIFF_BITS = MAP_BITS + 1;
    // One quotient bit per step: all numerator bits, then the fraction bits.
    localparam int DIV_STEPS = DIFF_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam int S_TDATA_BITS = 144;
    localparam int M_TDATA_BITS = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       wr_accept;
        logic       rd_accept;
        logic       lk_accept;
        logic       div_step;
        logic       split;
        logic       issue;
        logic       mul;
        logic       acc;
        logic [1:0] corner;
        logic       res_load;
        logic       res_lookup;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic res_free;
    } status_t;

endpackage

FILE: hdl/rebl_ram.sv
// Generic single-port RAM with registered read.
module rebl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle; a read updates the output register.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end
endmodule

FILE: hdl/rebl_axis.sv
// One axis: bit-serial signed division to a pixel position, then clamp and split.
module rebl_axis import rebl_pkg::*; #(
    parameter int MAX_N = 256
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic                          step,
    input  logic                          split,
    input  logic signed [DIFF_BITS-1:0]   diff,
    input  logic signed [MAP_BITS-1:0]    den,
    input  logic [$clog2(MAX_N+1)-1:0]    n_eff,
    output logic [$clog2(MAX_N)-1:0]      idx,
    output logic [FRAC_BITS:0]            frac
);
    localparam int NW = $clog2(MAX_N + 1);
    localparam int IW = $clog2(MAX_N);
    localparam int QW = 21 + FRAC_BITS;

    logic [DIFF_BITS-1:0] num_reg;
    logic [MAP_BITS-1:0]  den_reg;
    logic [MAP_BITS-1:0]  rem_reg, rem_next;
    logic [QW-1:0]        q_reg;
    logic                 ovf_reg, neg_reg, zero_reg;
    logic [MAP_BITS:0]    trial;
    logic                 ge;
    logic [20:0]          qi;
    logic [QW-1:0]        mag;
    logic signed [39:0]   pos, p2, hi, pc;
    logic [NW-1:0]        k;
    logic                 dec;

    // Restoring division step: bring down one numerator bit.
    assign trial = {rem_reg, num_reg[DIFF_BITS-1]};
    assign ge = trial >= {1'b0, den_reg};
    assign rem_next = ge ? MAP_BITS'(trial - {1'b0, den_reg}) : trial[MAP_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            num_reg  <= diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : diff;
            den_reg  <= den[MAP_BITS-1] ? MAP_BITS'(-den) : den;
            neg_reg  <= diff[DIFF_BITS-1] != den[MAP_BITS-1];
            zero_reg <= den == '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
        end else if (step) begin
            num_reg <= {num_reg[DIFF_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[QW-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[QW-1];
        end
    end

    // Integer part saturates at 2^20 before the sign is applied.
    assign qi  = (ovf_reg || q_reg[QW-1:FRAC_BITS] > 21'h100000) ? 21'h100000
                                                                 : q_reg[QW-1:FRAC_BITS];
    assign mag = {qi, q_reg[FRAC_BITS-1:0]};

    // Half-pixel shift and clamp to the used tile.
    always_comb begin
        pos = zero_reg ? '0 : (neg_reg ? -40'(mag) : 40'(mag));
        p2  = pos - 40'sd32768;
        hi  = (40'(n_eff) - 40'sd1) <<< FRAC_BITS;
        if (p2 < 0) begin
            pc = '0;
        end else if (p2 > hi) begin
            pc = hi;
        end else begin
            pc = p2;
        end
        k   = pc[FRAC_BITS +: NW];
        dec = k == NW'(n_eff - NW'(1));
    end

    // Step back one cell at the far edge; the fraction is then one whole.
    always_ff @(posedge aclk) begin
        if (split) begin
            idx  <= IW'(dec ? k - NW'(1) : k);
            frac <= dec ? (FRAC_BITS+1)'(1 << FRAC_BITS) : {1'b0, pc[FRAC_BITS-1:0]};
        end
    end
endmodule

FILE: hdl/rebl_datapath.sv
// Datapath: configuration, sample store, axis dividers, blend and result register.
module rebl_datapath import rebl_pkg::*; #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [MAP_BITS-1:0]     cfg_data,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  cmd_t                    cmd,
    output status_t                 status,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic                    m_tuser
);
    localparam int SB    = SAMPLE_BITS < 32 ? SAMPLE_BITS : 32;
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNW   = $clog2(MAX_COLUMNS + 1);
    localparam int RNW   = $clog2(MAX_ROWS + 1);
    localparam int CIW   = $clog2(MAX_COLUMNS);
    localparam int RIW   = $clog2(MAX_ROWS);

    logic signed [MAP_BITS-1:0] origin_x_reg, origin_y_reg, cell_width_reg, cell_height_reg;
    logic [8:0]                 columns_used_reg, rows_used_reg;
    logic [31:0]                missing_marker_reg;

    logic [7:0]                 in_col, in_row;
    logic [31:0]                in_sample;
    logic signed [MAP_BITS-1:0] in_map_x, in_map_y;
    logic [CNW-1:0]             cols_eff;
    logic [RNW-1:0]             rows_eff;
    logic                       wr_in, rd_in, rd_ok_reg;
    logic [CIW-1:0]             xi;
    logic [RIW-1:0]             yi;
    logic [FRAC_BITS:0]         fx, fy, wx, wy;
    logic [32:0]                w_reg;
    logic [AW-1:0]              in_addr, corner_addr, ram_addr;
    logic                       ram_en;
    logic [SB-1:0]              rdata;
    logic signed [31:0]         sample;
    logic                       is_missing;
    logic signed [66:0]         prod_full;
    logic signed [65:0]         prod_reg, acc_reg, rnd;
    logic                       ok_reg;
    logic                       m_tvalid_reg;
    logic [31:0]                m_tdata_reg;
    logic                       m_tuser_reg;

    // Input item fields.
    assign in_col    = s_tdata[7:0];
    assign in_row    = s_tdata[15:8];
    assign in_sample = s_tdata[47:16];
    assign in_map_x  = s_tdata[95:48];
    assign in_map_y  = s_tdata[143:96];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            cell_width_reg     <= 48'sd65536;
            cell_height_reg    <= -48'sd65536;
            columns_used_reg   <= 9'd256;
            rows_used_reg      <= 9'd256;
            missing_marker_reg <= 32'h8000_0000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ORIGIN_X:    origin_x_reg       <= cfg_data;
                REG_ORIGIN_Y:    origin_y_reg       <= cfg_data;
                REG_CELL_WIDTH:  cell_width_reg     <= cfg_data;
                REG_CELL_HEIGHT: cell_height_reg    <= cfg_data;
                REG_COLUMNS:     columns_used_reg   <= cfg_data[8:0];
                REG_ROWS:        rows_used_reg      <= cfg_data[8:0];
                REG_MISSING:     missing_marker_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Tile size saturated to at least two and at most the store bounds.
    assign cols_eff = (columns_used_reg < 9'd2) ? CNW'(2)
                    : (32'(columns_used_reg) > MAX_COLUMNS) ? CNW'(MAX_COLUMNS)
                    : CNW'(columns_used_reg);
    assign rows_eff = (rows_used_reg < 9'd2) ? RNW'(2)
                    : (32'(rows_used_reg) > MAX_ROWS) ? RNW'(MAX_ROWS)
                    : RNW'(rows_used_reg);

    assign wr_in = 32'(in_col) < MAX_COLUMNS && 32'(in_row) < MAX_ROWS;
    assign rd_in = 32'(in_col) < 32'(cols_eff) && 32'(in_row) < 32'(rows_eff);

    // Axis units: position, clamp and split.
    rebl_axis #(.MAX_N(MAX_COLUMNS)) u_axis_x (
        .aclk(aclk), .load(cmd.lk_accept), .step(cmd.div_step), .split(cmd.split),
        .diff(DIFF_BITS'(in_map_x) - DIFF_BITS'(origin_x_reg)),
        .den(cell_width_reg), .n_eff(cols_eff), .idx(xi), .frac(fx)
    );
    rebl_axis #(.MAX_N(MAX_ROWS)) u_axis_y (
        .aclk(aclk), .load(cmd.lk_accept), .step(cmd.div_step), .split(cmd.split),
        .diff(DIFF_BITS'(in_map_y) - DIFF_BITS'(origin_y_reg)),
        .den(cell_height_reg), .n_eff(rows_eff), .idx(yi), .frac(fy)
    );

    // Store addressing: incoming item or current corner.
    assign in_addr     = AW'(AW'(in_row) * AW'(MAX_COLUMNS) + AW'(in_col));
    assign corner_addr = AW'(AW'(yi + RIW'(cmd.corner[1])) * AW'(MAX_COLUMNS)
                         + AW'(xi + CIW'(cmd.corner[0])));
    assign ram_addr    = cmd.issue ? corner_addr : in_addr;
    assign ram_en      = (cmd.wr_accept && wr_in) || (cmd.rd_accept && rd_in) || cmd.issue;

    rebl_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_store (
        .aclk(aclk), .en(ram_en), .we(cmd.wr_accept), .addr(ram_addr),
        .wdata(in_sample[SB-1:0]), .rdata(rdata)
    );

    assign sample     = 32'($signed(rdata));
    assign is_missing = rdata == missing_marker_reg[SB-1:0];

    // Corner weight, one product per corner.
    assign wx = cmd.corner[0] ? fx : (FRAC_BITS+1)'((1 << FRAC_BITS) - 32'(fx));
    assign wy = cmd.corner[1] ? fy : (FRAC_BITS+1)'((1 << FRAC_BITS) - 32'(fy));
    assign prod_full = 67'(sample) * 67'($signed({2'b00, w_reg}));

    // Blend: weight, multiply, accumulate; track missing corners.
    always_ff @(posedge aclk) begin
        if (cmd.rd_accept) begin
            rd_ok_reg <= rd_in;
        end
        if (cmd.issue) begin
            w_reg <= 33'(34'(wx) * 34'(wy));
        end
        if (cmd.mul) begin
            prod_reg <= prod_full[65:0];
        end
        if (cmd.lk_accept) begin
            acc_reg <= '0;
            ok_reg  <= 1'b1;
        end else begin
            if (cmd.acc) begin
                acc_reg <= acc_reg + prod_reg;
            end
            if (cmd.mul && is_missing) begin
                ok_reg <= 1'b0;
            end
        end
    end

    // Round to nearest, ties upward.
    assign rnd = acc_reg + 66'sd2147483648;

    // Result register; it holds until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            if (cmd.res_lookup) begin
                m_tdata_reg <= ok_reg ? rnd[63:32] : '0;
                m_tuser_reg <= ok_reg;
            end else begin
                m_tdata_reg <= (rd_ok_reg && !is_missing) ? sample : '0;
                m_tuser_reg <= rd_ok_reg && !is_missing;
            end
        end
    end

    assign status.res_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule

FILE: hdl/rebl_ctrl.sv
// Controller: sequences accepts, division, corner reads and result loads.
module rebl_ctrl import rebl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    output logic       s_tready,
    input  status_t    status,
    output cmd_t       cmd
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_SPLIT = 8'b0000_0100,
        ST_ISSUE = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_ACC   = 8'b0010_0000,
        ST_LFIN  = 8'b0100_0000,
        ST_RFIN  = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]              corner_reg, corner_next;
    logic                    accept;

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        corner_next = corner_reg;
        cmd         = '0;
        cmd.corner  = corner_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.wr_accept = accept && s_tuser == FUNC_WRITE;
                cmd.rd_accept = accept && s_tuser == FUNC_READ;
                cmd.lk_accept = accept && s_tuser == FUNC_LOOKUP;
                cnt_next      = '0;
                corner_next   = '0;
                if (cmd.lk_accept) begin
                    state_next = ST_DIV;
                end else if (cmd.rd_accept) begin
                    state_next = ST_RFIN;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = DIV_CNT_BITS'(cnt_reg + 1'b1);
                if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                cmd.issue  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc     = 1'b1;
                corner_next = corner_reg + 2'd1;
                state_next  = (corner_reg == 2'd3) ? ST_LFIN : ST_ISSUE;
            end
            ST_LFIN: begin
                if (status.res_free) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_lookup = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RFIN: begin
                if (status.res_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            corner_reg <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            corner_reg <= corner_next;
        end
    end

    // A result is never loaded over one that is still waiting.
    a_res_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> status.res_free) else $error("result overwritten");

    // Corner reads never share the store port with an accepted item.
    a_port_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.issue) else $error("store port conflict");

    // A lookup starts its division in the next cycle.
    a_lookup_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lk_accept |=> state_reg == ST_DIV) else $error("lookup not started");

    // The fourth corner ends the blend.
    a_blend_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc && corner_reg == 2'd3) |=> state_reg == ST_LFIN)
        else $error("blend did not finish");
endmodule

FILE: hdl/raster_elevation_bilinear_lookup.sv
// Top level of the raster elevation bilinear lookup.
//
//  Channel  Direction  Contents
//  s_       in         tuser: func; tdata: pixel_col, pixel_row, sample_value, map_x, map_y
//  m_       out        tuser: elevation_valid; tdata: elevation
//  cfg_     in         register index and write data, one write per cycle
//
// A write item goes to the store when it is accepted. A read item goes through ST_RFIN
// to the output register. A lookup runs the accept, 65 steps of the two bit-serial axis
// dividers, a split, then issue, multiply and accumulate per corner on the single store
// port, and one load. Reset is synchronous and clears control and configuration; the
// sample store is not cleared. A waiting result holds in the output register while the
// next item is accepted; a stalled one holds up the next read or lookup and all input.
module raster_elevation_bilinear_lookup import rebl_pkg::*; #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // pixel_col[7:0], pixel_row[15:8], sample_value[47:16], map_x[95:48], map_y[143:96]
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    // func[1:0]
    input  logic [1:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // elevation[31:0]
    output logic [M_TDATA_BITS-1:0] m_tdata,
    // elevation_valid[0]
    output logic                    m_tuser,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [MAP_BITS-1:0]     cfg_data
);
    cmd_t    cmd;
    status_t status;

    rebl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tuser(s_tuser),
        .s_tready(s_tready), .status(status), .cmd(cmd)
    );

    rebl_datapath #(
        .MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tdata(s_tdata), .cmd(cmd), .status(status),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );
endmodule

FILE: test/raster_elevation_bilinear_lookup_test.sv
// Self-checking testbench for the raster elevation bilinear lookup block.
`timescale 1ns / 100ps

module raster_elevation_bilinear_lookup_test;
    import rebl_pkg::*;

    localparam int TILE_SIDE = 256;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [31:0] elevation;
        logic        valid;
    } elevation_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic [1:0]              s_tuser = FUNC_WRITE;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tuser;
    logic                    cfg_wr_en = 1'b0;
    logic [2:0]              cfg_index = REG_ORIGIN_X;
    logic [MAP_BITS-1:0]     cfg_data = '0;

    // Mirror of the tile store and of the configuration.
    logic [31:0] tile_mirror [TILE_SIDE*TILE_SIDE];
    bit          tile_written [TILE_SIDE*TILE_SIDE];
    longint      origin_x_cfg, origin_y_cfg, cell_width_cfg, cell_height_cfg;
    int          columns_cfg, rows_cfg;
    logic [31:0] missing_cfg;

    elevation_t  pending_elevations[$];
    int          error_count = 0;
    int          idle_count = 0;
    bit          steady = 0;
    bit          hold_request = 0;
    int          hold_count = 0;

    always #5 aclk = ~aclk;

    raster_elevation_bilinear_lookup uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic int used_columns();
        return columns_cfg < 2 ? 2 : (columns_cfg > TILE_SIDE ? TILE_SIDE : columns_cfg);
    endfunction

    function automatic int used_rows();
        return rows_cfg < 2 ? 2 : (rows_cfg > TILE_SIDE ? TILE_SIDE : rows_cfg);
    endfunction

    // Pixel position in Q.16: exact quotient truncated toward zero, integer part saturated.
    function automatic longint pixel_position(longint diff, longint den);
        longint unsigned n, d, whole, rem, frac;
        longint          mag;
        bit              neg;
        if (den == 0) return 0;
        neg = (diff < 0) != (den < 0);
        n = diff < 0 ? -diff : diff;
        d = den < 0 ? -den : den;
        whole = n / d;
        rem = n % d;
        if (whole > (64'd1 << 20)) whole = 64'd1 << 20;
        frac = 0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= d) begin
                rem = rem - d;
                frac = frac | 1;
            end
        end
        mag = longint'((whole << FRAC_BITS) | frac);
        return neg ? -mag : mag;
    endfunction

    // Shift by half a pixel, clamp to the tile and step back at the far edge.
    function automatic void split_axis(input longint pos, input int n,
                                       output int idx, output longint frac);
        longint hi;
        hi = longint'(n - 1) << FRAC_BITS;
        pos = pos - (64'sd1 <<< (FRAC_BITS - 1));
        if (pos < 0) pos = 0;
        if (pos > hi) pos = hi;
        idx = int'(pos >>> FRAC_BITS);
        if (idx == n - 1) idx = idx - 1;
        frac = pos - (longint'(idx) << FRAC_BITS);
    endfunction

    function automatic void lookup_cell(input logic [47:0] mx, input logic [47:0] my,
                                        output int xi, output int yi,
                                        output longint fx, output longint fy);
        longint px, py;
        px = pixel_position(longint'($signed(mx)) - origin_x_cfg, cell_width_cfg);
        py = pixel_position(longint'($signed(my)) - origin_y_cfg, cell_height_cfg);
        split_axis(px, used_columns(), xi, fx);
        split_axis(py, used_rows(), yi, fy);
    endfunction

    // Applies one accepted item to the mirror and queues the elevation it produces.
    function automatic void predict_elevation(logic [1:0] func, logic [S_TDATA_BITS-1:0] d);
        elevation_t  res;
        int          col, row, xi, yi, addr;
        longint      fx, fy;
        logic [31:0] corner [4];
        bit [63:0]   wx0, wx1, wy0, wy1, sum, u;
        col = int'(d[7:0]);
        row = int'(d[15:8]);
        res.valid = 1'b1;
        res.elevation = '0;
        case (func)
            FUNC_WRITE: begin
                addr = row * TILE_SIDE + col;
                tile_mirror[addr] = d[47:16];
                tile_written[addr] = 1;
                return;
            end
            FUNC_READ: begin
                if (col >= used_columns() || row >= used_rows()) begin
                    res.valid = 1'b0;
                end else begin
                    res.elevation = tile_mirror[row * TILE_SIDE + col];
                    if (res.elevation == missing_cfg) res.valid = 1'b0;
                end
            end
            FUNC_LOOKUP: begin
                lookup_cell(d[95:48], d[143:96], xi, yi, fx, fy);
                corner[0] = tile_mirror[yi * TILE_SIDE + xi];
                corner[1] = tile_mirror[yi * TILE_SIDE + xi + 1];
                corner[2] = tile_mirror[(yi + 1) * TILE_SIDE + xi];
                corner[3] = tile_mirror[(yi + 1) * TILE_SIDE + xi + 1];
                for (int k = 0; k < 4; k++)
                    if (corner[k] == missing_cfg) res.valid = 1'b0;
                wx1 = fx;
                wx0 = (64'd1 << FRAC_BITS) - fx;
                wy1 = fy;
                wy0 = (64'd1 << FRAC_BITS) - fy;
                sum = 64'(longint'($signed(corner[0]))) * (wx0 * wy0)
                    + 64'(longint'($signed(corner[1]))) * (wx1 * wy0)
                    + 64'(longint'($signed(corner[2]))) * (wx0 * wy1)
                    + 64'(longint'($signed(corner[3]))) * (wx1 * wy1);
                u = sum ^ (64'd1 << 63);
                u = u + (64'd1 << 31);
                u = u >> 32;
                res.elevation = u[31:0] - 32'h8000_0000;
                if (!res.valid) res.elevation = '0;
            end
            default: return;
        endcase
        if (!res.valid) res.elevation = '0;
        pending_elevations.insert(pending_elevations.size(), res);
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("%0t: mismatch: %s", $realtime, what);
    endtask

    // Sends one item and updates the prediction when it is accepted.
    task automatic send_item(logic [1:0] func, int col, int row, logic [31:0] sample,
                             logic [47:0] mx, logic [47:0] my);
        if (!steady && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {my, mx, sample, 8'(row), 8'(col)};
        do @(posedge aclk); while (!s_tready);
        predict_elevation(func, {my, mx, sample, 8'(row), 8'(col)});
    endtask

    function automatic logic [31:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 12) return missing_cfg;
        if (r < 16) return 32'h7FFF_FFFF;
        if (r < 20) return 32'h8000_0000;
        if (r < 30) return 32'(int'($urandom_range(0, 4095)) - 2048);
        return $urandom;
    endfunction

    function automatic logic [47:0] random_map();
        return {16'($urandom), $urandom};
    endfunction

    task automatic write_if_empty(int col, int row);
        if (!tile_written[row * TILE_SIDE + col])
            send_item(FUNC_WRITE, col, row, pick_sample(), random_map(), random_map());
    endtask

    // A lookup whose corners have not been loaded is preceded by writes for them.
    task automatic send_lookup(logic [47:0] mx, logic [47:0] my);
        int     xi, yi;
        longint fx, fy;
        lookup_cell(mx, my, xi, yi, fx, fy);
        write_if_empty(xi, yi);
        write_if_empty(xi + 1, yi);
        write_if_empty(xi, yi + 1);
        write_if_empty(xi + 1, yi + 1);
        send_item(FUNC_LOOKUP, $urandom_range(255), $urandom_range(255), $urandom, mx, my);
    endtask

    task automatic send_read(int col, int row);
        if (col < used_columns() && row < used_rows()) write_if_empty(col, row);
        send_item(FUNC_READ, col, row, $urandom, random_map(), random_map());
    endtask

    // Waits until every elevation is back and the block has gone quiet.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_elevations.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [2:0] index, logic [47:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        case (index)
            REG_ORIGIN_X:    origin_x_cfg = longint'($signed(value));
            REG_ORIGIN_Y:    origin_y_cfg = longint'($signed(value));
            REG_CELL_WIDTH:  cell_width_cfg = longint'($signed(value));
            REG_CELL_HEIGHT: cell_height_cfg = longint'($signed(value));
            REG_COLUMNS:     columns_cfg = int'(value[8:0]);
            REG_ROWS:        rows_cfg = int'(value[8:0]);
            REG_MISSING:     missing_cfg = value[31:0];
            default: ;
        endcase
    endtask

    task automatic configure(longint ox, longint oy, longint cw, longint ch,
                             int cols, int rows, logic [31:0] marker);
        wait_drained();
        write_register(REG_ORIGIN_X, 48'(ox));
        write_register(REG_ORIGIN_Y, 48'(oy));
        write_register(REG_CELL_WIDTH, 48'(cw));
        write_register(REG_CELL_HEIGHT, 48'(ch));
        write_register(REG_COLUMNS, 48'(cols));
        write_register(REG_ROWS, 48'(rows));
        write_register(REG_MISSING, {16'd0, marker});
        cfg_wr_en <= 1'b0;
    endtask

    // Map coordinate that lands near a pixel position, mostly inside the tile.
    function automatic logic [47:0] map_near(longint origin, longint cell_size, int n);
        longint p;
        if ($urandom_range(9) == 0) return random_map();
        p = longint'($urandom_range(0, (n + 2) * 65536)) - 65536;
        return 48'(origin + ((p * cell_size) >>> FRAC_BITS));
    endfunction

    // Small tile with edge values, every operation and the edge cases.
    task automatic test_directed();
        configure(0, 0, 65536, -65536, 4, 4, 32'h8000_0000);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_item(FUNC_WRITE, c, r,
                          (r == 1 && c == 2) ? 32'h8000_0000 :
                          (c == 3) ? 32'h7FFF_FFFF : (c == 0 ? 32'h8000_0001 : r * 256 + c),
                          '0, '0);
        send_read(0, 0);
        send_read(3, 3);
        send_read(2, 1);
        send_read(4, 0);
        send_read(255, 255);
        // Centered, clamped on both sides, on the far edge and at extreme coordinates.
        send_lookup(48'sd98304, -48'sd98304);
        send_lookup(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        send_lookup(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        send_lookup(48'sd229376, -48'sd229376);
        send_lookup(48'sd163840, -48'sd32768);
        send_item(FUNC_UNUSED, 255, 255, 32'hFFFF_FFFF, '1, '1);
        configure(0, 0, 0, 0, 4, 4, 32'h8000_0000);
        send_lookup(48'sd12345, 48'sd54321);
    endtask

    task automatic run_random(int count);
        int r, cols, rows;
        cols = used_columns();
        rows = used_rows();
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 30)
                send_item(FUNC_WRITE, $urandom_range(cols - 1), $urandom_range(rows - 1),
                          pick_sample(), random_map(), random_map());
            else if (r < 60)
                send_lookup(map_near(origin_x_cfg, cell_width_cfg, cols),
                            map_near(origin_y_cfg, cell_height_cfg, rows));
            else if (r < 80)
                send_read($urandom_range(cols < 255 ? cols + 1 : 255),
                          $urandom_range(rows < 255 ? rows + 1 : 255));
            else if (r < 90) begin
                case ($urandom_range(3))
                    0: send_item(FUNC_WRITE, $urandom_range(255), $urandom_range(255),
                                 $urandom, random_map(), random_map());
                    1: send_lookup(random_map(), random_map());
                    2: send_read($urandom_range(255), $urandom_range(255));
                    default: send_item(FUNC_UNUSED, $urandom_range(255), $urandom_range(255),
                                       $urandom, random_map(), random_map());
                endcase
            end else
                send_item(FUNC_WRITE, $urandom_range(255), $urandom_range(255),
                          pick_sample(), random_map(), random_map());
        end
    endtask

    // Several tile settings, the extremes among them.
    task automatic test_random_settings();
        configure(0, 0, 65536, -65536, 8, 8, $urandom);
        run_random(120);
        configure($urandom, -$urandom, 1, -1, 2, 2, 32'h8000_0000);
        run_random(120);
        configure(-1000000, 7000000, 229376, -147456, 0, 1, 32'h0000_0000);
        run_random(120);
        configure(64'sh7FFF_FFFF_FFFF, -64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF,
                  -64'sh8000_0000_0000, 256, 256, 32'h7FFF_FFFF);
        run_random(120);
        configure(-64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF, 0, 0, 300, 511, 32'hFFFF_FF00);
        run_random(80);
        configure(123456, -654321, -65536, 65536, 16, 5, 32'h7FFF_FFFF);
        run_random(120);
    endtask

    // A stretch with no idling on either side.
    task automatic test_steady_stream();
        configure(0, 0, 65536, -65536, 12, 12, 32'h8000_0000);
        steady = 1;
        run_random(100);
        wait_drained();
        steady = 0;
    endtask

    // The receiver holds off while reads keep coming, so the block stalls its input.
    task automatic test_output_stall();
        hold_request = 1;
        for (int i = 0; i < 30; i++)
            send_read($urandom_range(11), $urandom_range(11));
    endtask

    // Result side: random ready, with a long hold when a test requests one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 0;
            hold_count = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_count > 0) begin
            hold_count--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 29);
        end
    end

    // Compares each accepted elevation with the oldest prediction.
    always @(posedge aclk) begin
        elevation_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_elevations.size() == 0) begin
                report_mismatch($sformatf("unexpected item %h/%b", m_tdata, m_tuser));
            end else begin
                want = pending_elevations.pop_front();
                if (m_tdata !== want.elevation)
                    report_mismatch($sformatf("elevation %h, want %h",
                                              m_tdata, want.elevation));
                if (m_tuser !== want.valid)
                    report_mismatch($sformatf("elevation_valid %b, want %b",
                                              m_tuser, want.valid));
            end
        end
    end

    // Ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("raster_elevation_bilinear_lookup regression: fail");
            $finish;
        end
    end

    initial begin
        origin_x_cfg = 0;
        origin_y_cfg = 0;
        cell_width_cfg = 65536;
        cell_height_cfg = -65536;
        columns_cfg = 256;
        rows_cfg = 256;
        missing_cfg = 32'h8000_0000;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_settings();
        test_steady_stream();
        test_output_stall();
        wait_drained();
        if (error_count == 0)
            $display("raster_elevation_bilinear_lookup regression: pass");
        else
            $display("raster_elevation_bilinear_lookup regression: fail");
        $finish;
    end

endmodule
